// File: hw/rtl/pnc_pkg.sv
package pnc_pkg;

    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned ENTRY_W    = 32;
    localparam int unsigned INDEX_W    = 8;
    localparam int unsigned CH_W       = 16;
    localparam int unsigned SCORE_W    = 34;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'd1;

    localparam logic [1:0] MODE_OFF       = 2'd0;
    localparam logic [1:0] MODE_PREMUL    = 2'd1;
    localparam logic [1:0] MODE_NONPREMUL = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CH_W-1:0] CH_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    function automatic logic [CH_W-1:0] widen(input logic [7:0] v);
        return {v, v};
    endfunction

    // floor(x / 0xFFFF) for x <= 0xFFFF * 0xFFFF
    function automatic logic [CH_W-1:0] div_max(input logic [2*CH_W-1:0] x);
        logic [CH_W-1:0] q0;
        logic [CH_W:0]   r;
        q0 = x[2*CH_W-1:CH_W];
        r  = {1'b0, x[CH_W-1:0]} + {1'b0, q0};
        return (r >= {1'b0, CH_MAX}) ? q0 + 16'd1 : q0;
    endfunction

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] x,
                                                 input logic [CH_W-1:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

endpackage

// File: hw/rtl/pnc_if.sv
interface pnc_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  entry_index;
    logic [31:0] entry_bgra;
    logic [31:0] query_color;

    modport source (output valid, kind, entry_index, entry_bgra, query_color,
                    input ready);
    modport sink (input valid, kind, entry_index, entry_bgra, query_color,
                  output ready);
endinterface

interface pnc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] near_index;

    modport source (output valid, near_index, input ready);
    modport sink (input valid, near_index, output ready);
endinterface

// File: hw/rtl/palette_nearest_color_search.sv
// Nearest palette color search.
// Channel req carries items: kind 0 writes entry_bgra into palette slot
// entry_index (slots at PALETTE_DEPTH or above are dropped), kind 1 is a query
// with a premultiplied ARGB color. Channel rsp returns one near_index item per
// query, none per write. Both use valid/ready; an item moves when both are high.
// cfg_we/cfg_index/cfg_wdata write palette_entries (index 0) and palette_mode
// (index 1); write them only while no item is in flight.
// A query searching N entries reads one palette word per cycle from the
// single-port memory and runs it through a five-stage
// premultiply/difference/square/sum/compare pipeline: the result goes to the
// rsp register once the pipeline has drained after the last entry.
// A query in mode 0 or 3, or with N = 0, answers 0 without a search.
// req.ready is high only while idle. A finished result waits in the rsp
// register; a stalled receiver holds the next query's result until rsp is free.
// Reset clears the configuration registers, the control state and the pipeline
// valid bits; palette contents are undefined until written.
module palette_nearest_color_search
    import pnc_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pnc_req_if.sink               req,
    pnc_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
    localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CFG_DATA_W-1:0] DEPTH_CFG = CFG_DATA_W'(PALETTE_DEPTH);

    logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

    logic [CFG_DATA_W-1:0] entries_reg;
    logic [1:0]            mode_reg;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [SCORE_W-1:0]    low_score_reg, low_score_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]    out_best_reg, out_best_next;

    logic [CH_W-1:0]       qa_reg, qr_reg, qg_reg, qb_reg;

    logic                  acc;
    logic                  issue;
    logic                  mem_we;
    logic                  nonpremul;
    logic                  mode_on;
    logic [CFG_DATA_W-1:0] n_sat;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0]      idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [2*CH_W-1:0]     prod_b_reg, prod_g_reg, prod_r_reg;
    logic [CH_W-1:0]       a2_reg;
    logic [CH_W-1:0]       d_a_reg, d_r_reg, d_g_reg, d_b_reg;
    logic [2*CH_W-1:0]     sq_a_reg, sq_r_reg, sq_g_reg, sq_b_reg;
    logic [SCORE_W-1:0]    sum_reg;

    logic [CH_W-1:0]       ea, er, eg, eb;
    logic [CH_W-1:0]       cb, cg, cr;

    assign acc       = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.near_index = out_best_reg;

    assign nonpremul = (mode_reg == MODE_NONPREMUL);
    assign mode_on   = (mode_reg == MODE_PREMUL) || (mode_reg == MODE_NONPREMUL);
    assign n_sat     = (entries_reg > DEPTH_CFG) ? DEPTH_CFG : entries_reg;
    assign issue     = (state_reg == ST_SCAN);
    assign mem_we    = acc && (req.kind == KIND_WRITE)
                       && ({1'b0, req.entry_index} < DEPTH_CFG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
            mode_reg    <= MODE_OFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENTRIES: entries_reg <= cfg_wdata;
                REG_MODE:    mode_reg    <= cfg_wdata[1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[req.entry_index[IDX_W-1:0]] <= req.entry_bgra;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_cnt_next     = rd_cnt_reg;
        n_next          = n_reg;
        best_next       = best_reg;
        low_score_next  = low_score_reg;
        out_valid_next  = out_valid_reg;
        out_best_next   = out_best_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (v5_reg && (sum_reg < low_score_reg))
        begin
            low_score_next = sum_reg;
            best_next      = idx5_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (acc && (req.kind == KIND_QUERY))
                begin
                    best_next       = '0;
                    low_score_next  = '1;
                    rd_cnt_next     = '0;
                    if (mode_on && (n_sat != '0))
                    begin
                        n_next     = CNT_W'(n_sat);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        n_next     = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (CNT_W'(rd_cnt_reg + 1'b1) == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = INDEX_W'(best_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            n_reg          <= '0;
            best_reg       <= '0;
            low_score_reg  <= '1;
            out_valid_reg  <= 1'b0;
            out_best_reg   <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            n_reg          <= n_next;
            best_reg       <= best_next;
            low_score_reg  <= low_score_next;
            out_valid_reg  <= out_valid_next;
            out_best_reg   <= out_best_next;
            v1_reg         <= issue;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            v4_reg         <= v3_reg;
            v5_reg         <= v4_reg;
        end
    end

    assign ea = widen(rd_data_reg[31:24]);
    assign er = widen(rd_data_reg[23:16]);
    assign eg = widen(rd_data_reg[15:8]);
    assign eb = widen(rd_data_reg[7:0]);

    assign cb = nonpremul ? div_max(prod_b_reg) : prod_b_reg[CH_W-1:0];
    assign cg = nonpremul ? div_max(prod_g_reg) : prod_g_reg[CH_W-1:0];
    assign cr = nonpremul ? div_max(prod_r_reg) : prod_r_reg[CH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (acc && (req.kind == KIND_QUERY))
        begin
            qa_reg <= widen(req.query_color[31:24]);
            qr_reg <= widen(req.query_color[23:16]);
            qg_reg <= widen(req.query_color[15:8]);
            qb_reg <= widen(req.query_color[7:0]);
        end

        idx1_reg <= rd_cnt_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        idx5_reg <= idx4_reg;

        // premultiply
        a2_reg <= ea;
        if (nonpremul)
        begin
            prod_b_reg <= {16'd0, eb} * {16'd0, ea};
            prod_g_reg <= {16'd0, eg} * {16'd0, ea};
            prod_r_reg <= {16'd0, er} * {16'd0, ea};
        end
        else
        begin
            prod_b_reg <= {16'd0, eb};
            prod_g_reg <= {16'd0, eg};
            prod_r_reg <= {16'd0, er};
        end

        d_a_reg <= abs_diff(a2_reg, qa_reg);
        d_r_reg <= abs_diff(cr, qr_reg);
        d_g_reg <= abs_diff(cg, qg_reg);
        d_b_reg <= abs_diff(cb, qb_reg);

        sq_a_reg <= {16'd0, d_a_reg} * {16'd0, d_a_reg};
        sq_r_reg <= {16'd0, d_r_reg} * {16'd0, d_r_reg};
        sq_g_reg <= {16'd0, d_g_reg} * {16'd0, d_g_reg};
        sq_b_reg <= {16'd0, d_b_reg} * {16'd0, d_b_reg};

        sum_reg <= SCORE_W'(sq_a_reg) + SCORE_W'(sq_r_reg)
                 + SCORE_W'(sq_g_reg) + SCORE_W'(sq_b_reg);
    end

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg < n_reg))
        else $error("scan address beyond entry count");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg))
        else $error("search pipeline busy while idle");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (n_reg != '0)) |-> (CNT_W'(best_reg) < n_reg))
        else $error("best index outside searched entries");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (req.kind == KIND_QUERY))
        |=> ((state_reg == ST_SCAN) || (state_reg == ST_DONE)))
        else $error("query item did not start a search");

endmodule
